FILE: hw/rtl/loiter_detector_macros.svh
// Assertion macros shared by the loiter detector RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef LOITER_DETECTOR_MACROS_SVH
`define LOITER_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define LD_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define LD_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ld_pkg.sv
// Types, constants and stream layout for the loiter detector.
// No dependencies; imported by every module of the block.
package ld_pkg;

  localparam int MAX_TRACKS = 64;
  localparam int COORD_BITS = 12;
  localparam int TRK_W      = $clog2(MAX_TRACKS);

  // input field widths
  localparam int ID_W    = 6;
  localparam int CLASS_W = 8;
  localparam int ID_CMP_W = ((ID_W > TRK_W) ? ID_W : TRK_W) + 1;

  // in_tdata layout, lowest bit first
  localparam int OFS_ID     = 0;
  localparam int OFS_CLASS  = OFS_ID + ID_W;
  localparam int OFS_LEFT   = OFS_CLASS + CLASS_W;
  localparam int OFS_TOP    = OFS_LEFT + COORD_BITS;
  localparam int OFS_RIGHT  = OFS_TOP + COORD_BITS;
  localparam int OFS_BOTTOM = OFS_RIGHT + COORD_BITS;
  localparam int IN_BITS    = OFS_BOTTOM + COORD_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = ((STATUS_W + 7) / 8) * 8;

  // configuration registers
  localparam int STAY_W  = 10;
  localparam int RATIO_W = 9;
  localparam int WIN_W   = 7;
  localparam int SLEEP_W = 7;
  localparam int DT_W    = 7;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STAY_THRESH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_RATIO_Q8 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_FRAMES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_THRESH = 3'd4;

  localparam logic [STAY_W-1:0]  RST_STAY_THRESH     = 10'd10;
  localparam logic [RATIO_W-1:0] RST_DETECT_RATIO_Q8 = 9'd205;
  localparam logic [WIN_W-1:0]   RST_WINDOW_FRAMES   = 7'd8;
  localparam logic [SLEEP_W-1:0] RST_SLEEP_FRAMES    = 7'd8;
  localparam logic [DT_W-1:0]    RST_DISTANCE_THRESH = 7'd6;

  // result codes
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALARM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SUPP  = 2'd2;

  // still counter
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  // shared arithmetic unit
  localparam int OPND_W    = (COORD_BITS > STAY_W) ? COORD_BITS : STAY_W;
  localparam int PROD_W    = 2 * OPND_W + 1;
  localparam int RATIO_FRAC = 8;
  localparam int LVL_W     = STAY_W + RATIO_W - RATIO_FRAC;
  localparam int T2_W      = 2 * DT_W;

  typedef enum logic [1:0] {
    ALU_MUL     = 2'd0,  // a * b
    ALU_SQD     = 2'd1,  // |a - b|^2
    ALU_SQD_ACC = 2'd2   // result + |a - b|^2
  } alu_op_t;

  typedef struct packed {
    logic              en;
    alu_op_t           op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [CNT_W-1:0]      cnt;
  } tbl_word_t;

  typedef struct packed {
    logic             en;
    logic [TRK_W-1:0] addr;
    tbl_word_t        data;
  } tbl_wr_t;

  typedef struct packed {
    logic      valid;
    tbl_word_t data;
  } tbl_ent_t;

endpackage

FILE: hw/rtl/ld_alu.sv
// Shared multiply / squared-difference unit with a registered result.
// Depends on ld_pkg.
module ld_alu (
  input  logic                 clk,
  input  ld_pkg::alu_req_t     req,
  output logic [ld_pkg::PROD_W-1:0] res
);
  import ld_pkg::*;

  logic [PROD_W-1:0]   res_r;
  logic [PROD_W-1:0]   res_nxt;
  logic [OPND_W-1:0]   diff;
  logic [OPND_W-1:0]   mul_a;
  logic [OPND_W-1:0]   mul_b;
  logic [2*OPND_W-1:0] prod;
  logic [PROD_W-1:0]   base;

  always_comb begin
    diff = (req.a >= req.b) ? (req.a - req.b) : (req.b - req.a);
    unique case (req.op)
      ALU_MUL: begin
        mul_a = req.a;
        mul_b = req.b;
        base  = '0;
      end
      ALU_SQD: begin
        mul_a = diff;
        mul_b = diff;
        base  = '0;
      end
      ALU_SQD_ACC: begin
        mul_a = diff;
        mul_b = diff;
        base  = res_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        base  = '0;
      end
    endcase
    prod    = mul_a * mul_b;
    res_nxt = base + PROD_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: hw/rtl/ld_table.sv
// Per-track table: centers and still counts in one RAM, valid bits in flops.
// Depends on ld_pkg and loiter_detector_macros.svh.
`include "loiter_detector_macros.svh"

module ld_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [ld_pkg::TRK_W-1:0] rd_addr,
  input  ld_pkg::tbl_wr_t          wr,
  input  logic                     clr_all,
  output ld_pkg::tbl_ent_t         rd_ent
);
  import ld_pkg::*;

  tbl_word_t             mem [MAX_TRACKS];
  tbl_word_t             rd_word_r;
  logic                  rd_valid_r;
  logic [MAX_TRACKS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_word_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // clear wins over a same-cycle write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr_all) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_ent.valid = rd_valid_r;
  assign rd_ent.data  = rd_word_r;

  `LD_ASSERT_NXT(a_clear_all, clk, rst_n, clr_all, valid_r == '0, "table not cleared")

endmodule

FILE: hw/rtl/loiter_detector.sv
// Loiter detector top level: stream ports, configuration registers, sequencer.
// Depends on ld_pkg, ld_alu, ld_table and loiter_detector_macros.svh.
//
// Tracks still persons per track id and reports one status beat per
// end-of-frame marker: no alarm, overstay alarm, or suppressed after an
// alarm. One item is worked on at a time and in_tready is low meanwhile.
// A person observation takes a table read, three passes through the
// shared multiplier (threshold square, dx squared, dy squared added) and
// a table write. Ignored observations are dropped in the idle state. An
// end-of-frame marker inside a window or while suppressed goes straight to
// the status output; one that closes a window first scans the track table
// through its single read port. A finished status waits in an output
// register, so the next item is taken while it is held.
`include "loiter_detector_macros.svh"

module loiter_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [5:0] track_id, [13:6] class_id, [25:14] box_left, [37:26] box_top,
  // [49:38] box_right, [61:50] box_bottom, rest zero
  input  logic [ld_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] func: 0 track observation, 1 end of frame
  input  logic                          in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] status, rest zero
  output logic [ld_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ld_pkg::CFG_W-1:0]      cfg_data
);
  import ld_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_T2   = 8'b0000_0010,
    S_DX   = 8'b0000_0100,
    S_DY   = 8'b0000_1000,
    S_WB   = 8'b0001_0000,
    S_LVL  = 8'b0010_0000,
    S_SCAN = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [STAY_W-1:0]  stay_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [WIN_W-1:0]   win_frames_r;
  logic [SLEEP_W-1:0] sleep_frames_r;
  logic [DT_W-1:0]    dist_r;

  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [TRK_W-1:0]      idx_r, idx_nxt;
  logic [T2_W-1:0]       t2_r, t2_nxt;
  logic [TRK_W:0]        scan_r, scan_nxt;
  logic                  alarm_r, alarm_nxt;
  logic [STATUS_W-1:0]   stat_r, stat_nxt;
  logic [WIN_W-1:0]      win_cnt_r, win_cnt_nxt;
  logic [SLEEP_W-1:0]    sleep_left_r, sleep_left_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_stat_r, out_stat_nxt;

  // input fields
  logic [ID_W-1:0]       f_id;
  logic [CLASS_W-1:0]    f_class;
  logic [COORD_BITS-1:0] f_left, f_top, f_right, f_bottom;
  logic [COORD_BITS:0]   sum_x, sum_y;

  logic                  in_acc;
  logic                  obs_take;
  logic [WIN_W-1:0]      wc_inc;
  logic                  scan_last;
  logic                  hit;
  logic                  still;
  logic [CNT_W-1:0]      cnt_new;
  logic [LVL_W-1:0]      level;
  logic                  emit_go;

  alu_req_t          alu_req;
  logic [PROD_W-1:0] alu_res;
  logic              tbl_rd_en;
  logic [TRK_W-1:0]  tbl_rd_addr;
  tbl_wr_t           tbl_wr;
  logic              tbl_clr;
  tbl_ent_t          tbl_ent;

  ld_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  ld_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .wr      (tbl_wr),
    .clr_all (tbl_clr),
    .rd_ent  (tbl_ent)
  );

  assign f_id     = in_tdata[OFS_ID +: ID_W];
  assign f_class  = in_tdata[OFS_CLASS +: CLASS_W];
  assign f_left   = in_tdata[OFS_LEFT +: COORD_BITS];
  assign f_top    = in_tdata[OFS_TOP +: COORD_BITS];
  assign f_right  = in_tdata[OFS_RIGHT +: COORD_BITS];
  assign f_bottom = in_tdata[OFS_BOTTOM +: COORD_BITS];
  assign sum_x    = {1'b0, f_left} + {1'b0, f_right};
  assign sum_y    = {1'b0, f_top} + {1'b0, f_bottom};

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign obs_take   = in_acc && !in_tuser && (sleep_left_r == '0) && (f_class == '0) &&
                      (ID_CMP_W'(f_id) < ID_CMP_W'(MAX_TRACKS));
  assign wc_inc     = win_cnt_r + WIN_W'(1);
  assign level      = alu_res[RATIO_FRAC +: LVL_W];
  assign scan_last  = (scan_r == (TRK_W + 1)'(MAX_TRACKS));
  assign hit        = (scan_r != '0) && tbl_ent.valid &&
                      (LVL_W'(tbl_ent.data.cnt) >= level);
  assign still      = alu_res < PROD_W'(t2_r);
  assign emit_go    = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_stat_r);

  always_comb begin
    if (!tbl_ent.valid || !still) begin
      cnt_new = CNT_W'(1);
    end else if (tbl_ent.data.cnt != COUNT_MAX) begin
      cnt_new = tbl_ent.data.cnt + CNT_W'(1);
    end else begin
      cnt_new = tbl_ent.data.cnt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    idx_nxt        = idx_r;
    t2_nxt         = t2_r;
    scan_nxt       = scan_r;
    alarm_nxt      = alarm_r;
    stat_nxt       = stat_r;
    win_cnt_nxt    = win_cnt_r;
    sleep_left_nxt = sleep_left_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_stat_nxt   = out_stat_r;
    alu_req        = '{en: 1'b0, op: ALU_MUL, a: '0, b: '0};
    tbl_rd_en      = 1'b0;
    tbl_rd_addr    = '0;
    tbl_wr         = '{en: 1'b0, addr: idx_r, data: '{cx: cx_r, cy: cy_r, cnt: cnt_new}};
    tbl_clr        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (obs_take) begin
          cx_nxt      = sum_x[COORD_BITS:1];
          cy_nxt      = sum_y[COORD_BITS:1];
          idx_nxt     = TRK_W'(f_id);
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = TRK_W'(f_id);
          state_nxt   = S_T2;
        end else if (in_acc && in_tuser) begin
          if (sleep_left_r != '0) begin
            sleep_left_nxt = sleep_left_r - SLEEP_W'(1);
            stat_nxt       = ST_SUPP;
            state_nxt      = S_EMIT;
          end else if ((wc_inc != '0) && (wc_inc < win_frames_r)) begin
            win_cnt_nxt = wc_inc;
            stat_nxt    = ST_NONE;
            state_nxt   = S_EMIT;
          end else begin
            win_cnt_nxt = '0;
            state_nxt   = S_LVL;
          end
        end
      end
      S_T2: begin
        alu_req   = '{en: 1'b1, op: ALU_MUL, a: OPND_W'(dist_r), b: OPND_W'(dist_r)};
        state_nxt = S_DX;
      end
      S_DX: begin
        t2_nxt    = alu_res[T2_W-1:0];
        alu_req   = '{en: 1'b1, op: ALU_SQD, a: OPND_W'(tbl_ent.data.cx), b: OPND_W'(cx_r)};
        state_nxt = S_DY;
      end
      S_DY: begin
        alu_req   = '{en: 1'b1, op: ALU_SQD_ACC,
                      a: OPND_W'(tbl_ent.data.cy), b: OPND_W'(cy_r)};
        state_nxt = S_WB;
      end
      S_WB: begin
        tbl_wr.en = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LVL: begin
        alu_req   = '{en: 1'b1, op: ALU_MUL, a: OPND_W'(ratio_r), b: OPND_W'(stay_r)};
        scan_nxt  = '0;
        alarm_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // read entry scan_r, judge the one read last cycle
        tbl_rd_en   = !scan_last;
        tbl_rd_addr = scan_r[TRK_W-1:0];
        scan_nxt    = scan_r + (TRK_W + 1)'(1);
        alarm_nxt   = alarm_r || hit;
        if (scan_last) begin
          tbl_clr   = 1'b1;
          state_nxt = S_EMIT;
          if (alarm_r || hit) begin
            stat_nxt       = ST_ALARM;
            sleep_left_nxt = sleep_frames_r;
          end else begin
            stat_nxt = ST_NONE;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      win_cnt_r      <= '0;
      sleep_left_r   <= '0;
      out_valid_r    <= 1'b0;
      stay_r         <= RST_STAY_THRESH;
      ratio_r        <= RST_DETECT_RATIO_Q8;
      win_frames_r   <= RST_WINDOW_FRAMES;
      sleep_frames_r <= RST_SLEEP_FRAMES;
      dist_r         <= RST_DISTANCE_THRESH;
    end else begin
      state_r      <= state_nxt;
      win_cnt_r    <= win_cnt_nxt;
      sleep_left_r <= sleep_left_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STAY_THRESH:     stay_r         <= cfg_data[STAY_W-1:0];
          REG_DETECT_RATIO_Q8: ratio_r        <= cfg_data[RATIO_W-1:0];
          REG_WINDOW_FRAMES:   win_frames_r   <= cfg_data[WIN_W-1:0];
          REG_SLEEP_FRAMES:    sleep_frames_r <= cfg_data[SLEEP_W-1:0];
          REG_DISTANCE_THRESH: dist_r         <= cfg_data[DT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    idx_r      <= idx_nxt;
    t2_r       <= t2_nxt;
    scan_r     <= scan_nxt;
    alarm_r    <= alarm_nxt;
    stat_r     <= stat_nxt;
    out_stat_r <= out_stat_nxt;
  end

  `LD_ASSERT_NXT(a_sleep_ignore, clk, rst_n, in_acc && !in_tuser && (sleep_left_r != '0), state_r == S_IDLE, "observation not ignored while suppressed")
  `LD_ASSERT_NXT(a_emit_load, clk, rst_n, (state_r == S_EMIT) && emit_go, out_valid_r && (out_stat_r == $past(stat_r)), "status beat not loaded")
  `LD_ASSERT_NXT(a_alarm_sleep, clk, rst_n, (state_r == S_SCAN) && scan_last && (alarm_r || hit), sleep_left_r == $past(sleep_frames_r), "suppression not armed after alarm")

endmodule
